// ===== src/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

	localparam int MAX_ORDER   = 8;
	localparam int FRAME_COUNT = 256;
	localparam int PAGE_BYTES  = 4096;

	localparam int FRAME_W    = 8;
	localparam int LINK_W     = 9;
	localparam int ORDER_W    = 4;
	localparam int REQ_W      = 21;
	localparam int STATUS_W   = 2;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PAGES_W    = REQ_W - PAGE_SHIFT + 1;

	localparam logic [LINK_W-1:0]  LINK_NIL   = LINK_W'(FRAME_COUNT);
	localparam logic [ORDER_W-1:0] ORDER_NONE = '1;
	localparam logic [ORDER_W-1:0] ORDER_TOP  = ORDER_W'(MAX_ORDER);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

	typedef struct packed {
		logic [ORDER_W-1:0] order;
		logic               used;
		logic [LINK_W-1:0]  link;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_ALOOK,
		OP_SPLIT,
		OP_FCHK,
		OP_FBUD,
		OP_FWALK,
		OP_FUNL,
		OP_FPUSH,
		OP_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   accept;
		logic   load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_free;
		logic fail;
		logic last;
		logic free_bad;
		logic at_max;
		logic bud_ok;
		logic bud_head;
		logic walk_hit;
		logic walk_end;
	} dp_stat_t;

	// Contents of a frame entry that has never been written.
	function automatic entry_t reset_entry(input logic [FRAME_W-1:0] addr);
		entry_t e;
		e.order = (addr == '0) ? ORDER_TOP : ORDER_NONE;
		e.used  = 1'b0;
		e.link  = LINK_NIL;
		return e;
	endfunction

	// Smallest order whose block covers the page count.
	function automatic logic [ORDER_W-1:0] ceil_order(input logic [PAGES_W-1:0] pages);
		logic [ORDER_W-1:0] r;
		r = '1;
		for (int j = PAGES_W - 1; j >= 0; j--) begin
			if ((PAGES_W'(1) << j) >= pages)
				r = ORDER_W'(j);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/bpa_req_if.sv =====
`default_nettype none
interface bpa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [bpa_pkg::REQ_W-1:0]     request_bytes;
	logic [bpa_pkg::FRAME_W-1:0]   block_index;

	modport source (output valid, command, request_bytes, block_index, input ready);
	modport sink (input valid, command, request_bytes, block_index, output ready);
endinterface
`default_nettype wire

// ===== src/bpa_rsp_if.sv =====
`default_nettype none
interface bpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bpa_pkg::STATUS_W-1:0]  status;
	logic [bpa_pkg::FRAME_W-1:0]   frame_index;
	logic [bpa_pkg::ORDER_W-1:0]   block_order;

	modport source (output valid, status, frame_index, block_order, input ready);
	modport sink (input valid, status, frame_index, block_order, output ready);
endinterface
`default_nettype wire

// ===== src/bpa_ram.sv =====
`default_nettype none
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/bpa_ctrl.sv =====
`default_nettype none
module bpa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	output      logic               out_valid,
	input  wire logic               out_ready,
	input  wire bpa_pkg::dp_stat_t  stat,
	output      bpa_pkg::ctl_cmd_t  cmd
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ALOOK = 9'b000000010,
		S_SPLIT = 9'b000000100,
		S_FCHK  = 9'b000001000,
		S_FBUD  = 9'b000010000,
		S_FWALK = 9'b000100000,
		S_FUNL  = 9'b001000000,
		S_FPUSH = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.op       = bpa_pkg::OP_IDLE;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid)
					state_d = stat.in_free ? S_FCHK : S_ALOOK;
			end
			S_ALOOK: begin
				cmd.op = bpa_pkg::OP_ALOOK;
				state_d = (stat.fail || stat.last) ? S_DONE : S_SPLIT;
			end
			S_SPLIT: begin
				cmd.op = bpa_pkg::OP_SPLIT;
				if (stat.last)
					state_d = S_DONE;
			end
			S_FCHK: begin
				cmd.op = bpa_pkg::OP_FCHK;
				priority if (stat.free_bad)
					state_d = S_DONE;
				else if (stat.at_max)
					state_d = S_FPUSH;
				else
					state_d = S_FBUD;
			end
			S_FBUD: begin
				cmd.op = bpa_pkg::OP_FBUD;
				priority if (!stat.bud_ok)
					state_d = S_FPUSH;
				else if (stat.bud_head)
					state_d = stat.at_max ? S_FPUSH : S_FBUD;
				else
					state_d = S_FWALK;
			end
			S_FWALK: begin
				cmd.op = bpa_pkg::OP_FWALK;
				if (stat.walk_hit || stat.walk_end)
					state_d = S_FUNL;
			end
			S_FUNL: begin
				cmd.op = bpa_pkg::OP_FUNL;
				state_d = stat.at_max ? S_FPUSH : S_FBUD;
			end
			S_FPUSH: begin
				cmd.op = bpa_pkg::OP_FPUSH;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.op = bpa_pkg::OP_DONE;
				cmd.load_out = slot_free;
				if (slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== src/bpa_dpath.sv =====
`default_nettype none
module bpa_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_command,
	input  wire logic [bpa_pkg::REQ_W-1:0]     in_request_bytes,
	input  wire logic [bpa_pkg::FRAME_W-1:0]   in_block_index,
	input  wire bpa_pkg::ctl_cmd_t             cmd,
	output      bpa_pkg::dp_stat_t             stat,
	output      logic [bpa_pkg::STATUS_W-1:0]  out_status,
	output      logic [bpa_pkg::FRAME_W-1:0]   out_frame_index,
	output      logic [bpa_pkg::ORDER_W-1:0]   out_block_order
);
	localparam int FW = bpa_pkg::FRAME_W;
	localparam int LW = bpa_pkg::LINK_W;
	localparam int OW = bpa_pkg::ORDER_W;
	localparam int PW = bpa_pkg::PAGES_W;

	logic [LW-1:0] head_q [bpa_pkg::MAX_ORDER+1];

	logic [OW-1:0] k_q, i_q;
	logic [FW-1:0] idx_q, cur_q;
	logic [LW-1:0] blink_q;
	logic          fail_q;

	logic [bpa_pkg::STATUS_W-1:0] res_st_q, out_st_q;
	logic [FW-1:0]                res_fr_q, out_fr_q;
	logic [OW-1:0]                res_od_q, out_od_q;

	logic [bpa_pkg::FRAME_COUNT-1:0] valid_q;
	logic                            rd_valid_q;
	logic [FW-1:0]                   rd_addr, rd_addr_q;
	logic                            wr_en;
	logic [FW-1:0]                   wr_addr;
	bpa_pkg::entry_t                 wr_data;
	logic [bpa_pkg::ENTRY_W-1:0]     ram_rdata;
	bpa_pkg::entry_t                 e;

	// Request decode
	logic [PW-1:0] pages;
	logic [OW-1:0] k_req;
	logic [OW-1:0] found_i;
	logic          found;
	logic [LW-1:0] start_head;

	// Per-step helpers
	logic [OW-1:0] im1;
	logic [FW-1:0] half;
	logic [FW-1:0] buddy;
	logic [FW-1:0] nidx;
	logic [FW-1:0] nbud;
	logic [OW-1:0] kp1;
	logic [FW-1:0] fbud;

	function automatic bpa_pkg::entry_t bpa_bpa_cast(input logic [bpa_pkg::ENTRY_W-1:0] v);
		return bpa_pkg::entry_t'(v);
	endfunction

	bpa_ram #(
		.WIDTH (bpa_pkg::ENTRY_W),
		.DEPTH (bpa_pkg::FRAME_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign e = rd_valid_q ? bpa_bpa_cast(ram_rdata) : bpa_pkg::reset_entry(rd_addr_q);

	always_comb begin
		pages = PW'(in_request_bytes[bpa_pkg::REQ_W-1:bpa_pkg::PAGE_SHIFT])
			+ PW'(|in_request_bytes[bpa_pkg::PAGE_SHIFT-1:0]);
		k_req = bpa_pkg::ceil_order(pages);
		found   = 1'b0;
		found_i = '0;
		for (int j = bpa_pkg::MAX_ORDER; j >= 0; j--) begin
			if (OW'(j) >= k_req && !head_q[j][LW-1]) begin
				found   = 1'b1;
				found_i = OW'(j);
			end
		end
		start_head = head_q[found_i];
	end

	assign im1  = i_q - OW'(1);
	assign half = cur_q + (FW'(1) << im1);
	assign buddy = idx_q ^ (FW'(1) << k_q);
	assign kp1  = k_q + OW'(1);
	assign nidx = idx_q & ~(FW'(1) << k_q);
	assign nbud = nidx ^ (FW'(1) << kp1);
	assign fbud = idx_q ^ (FW'(1) << e.order);

	always_comb begin
		stat.in_free  = (in_command == bpa_pkg::CMD_FREE);
		stat.fail     = fail_q;
		stat.last     = (cmd.op == bpa_pkg::OP_SPLIT) ? (im1 == k_q) : (i_q == k_q);
		stat.free_bad = !e.used || (e.order > bpa_pkg::ORDER_TOP);
		stat.at_max   = (cmd.op == bpa_pkg::OP_FCHK) ? (e.order == bpa_pkg::ORDER_TOP)
			: (kp1 == bpa_pkg::ORDER_TOP);
		stat.bud_ok   = !e.used && (e.order == k_q);
		stat.bud_head = (head_q[k_q] == {1'b0, buddy});
		stat.walk_hit = (e.link == {1'b0, buddy});
		stat.walk_end = e.link[LW-1];
	end

	always_comb begin
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = bpa_pkg::reset_entry(idx_q);
		if (cmd.accept)
			rd_addr = (in_command == bpa_pkg::CMD_FREE) ? in_block_index
				: start_head[FW-1:0];
		unique case (cmd.op)
			bpa_pkg::OP_ALOOK: begin
				if (!fail_q) begin
					wr_en   = 1'b1;
					wr_addr = cur_q;
					wr_data = '{order: k_q, used: 1'b1, link: bpa_pkg::LINK_NIL};
				end
			end
			bpa_pkg::OP_SPLIT: begin
				wr_en   = 1'b1;
				wr_addr = half;
				wr_data = '{order: im1, used: 1'b0, link: head_q[im1]};
			end
			bpa_pkg::OP_FCHK: begin
				if (!stat.free_bad) begin
					wr_en   = 1'b1;
					wr_addr = idx_q;
					wr_data = '{order: bpa_pkg::ORDER_NONE, used: 1'b0,
						link: bpa_pkg::LINK_NIL};
					rd_addr = fbud;
				end
			end
			bpa_pkg::OP_FBUD: begin
				if (stat.bud_ok) begin
					if (stat.bud_head) begin
						wr_en   = 1'b1;
						wr_addr = buddy;
						wr_data = '{order: bpa_pkg::ORDER_NONE, used: 1'b0,
							link: bpa_pkg::LINK_NIL};
						rd_addr = nbud;
					end else begin
						rd_addr = head_q[k_q][FW-1:0];
					end
				end
			end
			bpa_pkg::OP_FWALK: begin
				if (stat.walk_hit) begin
					wr_en   = 1'b1;
					wr_addr = cur_q;
					wr_data = '{order: e.order, used: e.used, link: blink_q};
				end else begin
					rd_addr = e.link[FW-1:0];
				end
			end
			bpa_pkg::OP_FUNL: begin
				wr_en   = 1'b1;
				wr_addr = buddy;
				wr_data = '{order: bpa_pkg::ORDER_NONE, used: 1'b0, link: bpa_pkg::LINK_NIL};
				rd_addr = nbud;
			end
			bpa_pkg::OP_FPUSH: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = '{order: k_q, used: 1'b0, link: head_q[k_q]};
			end
			bpa_pkg::OP_IDLE, bpa_pkg::OP_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int j = 0; j <= bpa_pkg::MAX_ORDER; j++)
				head_q[j] <= (j == bpa_pkg::MAX_ORDER) ? LW'(0) : bpa_pkg::LINK_NIL;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			unique case (cmd.op)
				bpa_pkg::OP_ALOOK: if (!fail_q) head_q[i_q] <= e.link;
				bpa_pkg::OP_SPLIT: head_q[im1] <= {1'b0, half};
				bpa_pkg::OP_FBUD:
					if (stat.bud_ok && stat.bud_head) head_q[k_q] <= e.link;
				bpa_pkg::OP_FPUSH: head_q[k_q] <= {1'b0, idx_q};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q  <= rd_addr;
		rd_valid_q <= valid_q[rd_addr];
		if (cmd.accept) begin
			idx_q  <= in_block_index;
			k_q    <= k_req;
			i_q    <= found_i;
			cur_q  <= start_head[FW-1:0];
			fail_q <= (k_req > bpa_pkg::ORDER_TOP) || !found;
		end
		unique case (cmd.op)
			bpa_pkg::OP_ALOOK: begin
				if (fail_q) begin
					res_st_q <= bpa_pkg::ST_NO_BLOCK;
					res_fr_q <= '0;
					res_od_q <= '0;
				end else begin
					res_st_q <= bpa_pkg::ST_OK;
					res_fr_q <= cur_q;
					res_od_q <= k_q;
				end
			end
			bpa_pkg::OP_SPLIT: begin
				i_q <= im1;
				res_st_q <= bpa_pkg::ST_OK;
				res_fr_q <= cur_q;
				res_od_q <= k_q;
			end
			bpa_pkg::OP_FCHK: begin
				k_q <= e.order;
				res_st_q <= bpa_pkg::ST_NOT_ALLOC;
				res_fr_q <= idx_q;
				res_od_q <= '0;
			end
			bpa_pkg::OP_FBUD: begin
				blink_q <= e.link;
				if (stat.bud_ok) begin
					if (stat.bud_head) begin
						k_q   <= kp1;
						idx_q <= nidx;
					end else begin
						cur_q <= head_q[k_q][FW-1:0];
					end
				end
			end
			bpa_pkg::OP_FWALK: if (!stat.walk_hit) cur_q <= e.link[FW-1:0];
			bpa_pkg::OP_FUNL: begin
				k_q   <= kp1;
				idx_q <= nidx;
			end
			bpa_pkg::OP_FPUSH: begin
				res_st_q <= bpa_pkg::ST_OK;
				res_fr_q <= idx_q;
				res_od_q <= k_q;
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			out_st_q <= res_st_q;
			out_fr_q <= res_fr_q;
			out_od_q <= res_od_q;
		end
	end

	assign out_status      = out_st_q;
	assign out_frame_index = out_fr_q;
	assign out_block_order = out_od_q;
endmodule
`default_nettype wire

// ===== src/buddy_page_allocator.sv =====
// Buddy page allocator over 256 page frames of 4096 bytes, free lists per order 0..8.
// req channel: command (0 allocate, 1 free), request_bytes, block_index.
// rsp channel: status, frame_index, block_order; exactly one response per request.
// One request is processed at a time. A request is taken only when the controller
// is idle; its response goes to an output register, so a new request may be
// taken while the previous response still waits on a stalled receiver.
// Allocate: a lookup of the free list at the smallest fitting order, then one
// split per order down to the order asked for. Free: a check of the block,
// then per merge a buddy check and, if the buddy does not head its list, a walk
// along that list to unlink it; then a push of the merged block. A rejected free
// ends after the check; an order-8 block is pushed straight after it.
// Every check, split, merge and list step goes in turn through the single read
// port of the frame table.
// If the receiver stalls, the finished response waits in the controller until
// the output register frees, and no new request is taken meanwhile.
// Reset: the whole space is one free block of order 8 at frame 0. Frame entries
// not yet written read as their reset contents through per-frame valid bits,
// so the block is ready straight after reset without clearing the table.
`default_nettype none
module buddy_page_allocator (
	input wire logic clk,
	input wire logic arst_n,
	bpa_req_if.sink  req,
	bpa_rsp_if.source rsp
);
	bpa_pkg::ctl_cmd_t cmd;
	bpa_pkg::dp_stat_t stat;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpa_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_command       (req.command),
		.in_request_bytes (req.request_bytes),
		.in_block_index   (req.block_index),
		.cmd              (cmd),
		.stat             (stat),
		.out_status       (rsp.status),
		.out_frame_index  (rsp.frame_index),
		.out_block_order  (rsp.block_order)
	);
endmodule
`default_nettype wire
